/* sv/rdsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_pkg: shared types and constants of the radix digit string converter
// Holds datapath widths, radix limits, register index codes, character
// constants, the controller state type and the divider status type.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    // Datapath widths
    localparam int VALUE_BITS = 63;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int BUF_DEPTH  = 64;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int COUNT_W    = ADDR_W + 1;
    localparam int DIG_W      = 6;
    localparam int CHAR_W     = 7;
    localparam int CFG_W      = 6;

    // Radix limits and reset value
    localparam logic [DIG_W-1:0] RADIX_MIN   = DIG_W'(2);
    localparam logic [DIG_W-1:0] RADIX_MAX   = DIG_W'(36);
    localparam logic [DIG_W-1:0] RADIX_RESET = DIG_W'(10);
    localparam logic [DIG_W-1:0] DIGIT_TEN   = DIG_W'(10);

    // Character bases; letter bases already have ten taken off
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_UPPER_10 = CHAR_W'(65 - 10);
    localparam logic [CHAR_W-1:0] CHAR_LOWER_10 = CHAR_W'(97 - 10);

    // Configuration register indexes
    typedef enum logic {
        CFG_RADIX = 1'b0,
        CFG_UPPER = 1'b1
    } t_cfg_idx;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD,
        ST_OUT
    } t_state;

    // Divider status toward the controller
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* sv/radix_digit_string_converter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_string_converter_unit: integer to base-N digit string
// Converts an unsigned value into its digits in a base of 2 to 36, emitted
// most significant first with ASCII character and a last-digit flag.
//
//   channel  | handshake                        | payload
//   ---------+----------------------------------+-------------------------------
//   value in | i_value_valid / o_value_ready    | i_value[62:0]
//   digit out| o_digit_valid / i_digit_ready    | o_digit_value, o_digit_char,
//            |                                  | o_last_digit
//   config   | i_cfg_we (no wait)               | i_cfg_addr, i_cfg_data
//
// Each digit comes from the bit-serial divider (one quotient bit per cycle
// over 63 bits); the value zero skips the divider and is stored as the
// single digit zero.
// Digits are emitted through a registered buffer read.
// Reset is synchronous, active low: radix returns to 10, lower-case letters.
// A stalled output holds its digit; no new value is taken until the last
// digit of the current one has been delivered.
// ----------------------------------------------------------------------------
module radix_digit_string_converter_unit
    import rdsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // Value input
    input  logic                  i_value_valid,
    output logic                  o_value_ready,
    input  logic [VALUE_BITS-1:0] i_value,
    // Digit output
    output logic                  o_digit_valid,
    input  logic                  i_digit_ready,
    output logic [DIG_W-1:0]      o_digit_value,
    output logic [CHAR_W-1:0]     o_digit_char,
    output logic                  o_last_digit
);

    t_state                r_state, n_state;
    logic [DIG_W-1:0]      r_radix;
    logic                  r_upper;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [ADDR_W-1:0]     r_ptr, n_ptr;

    logic [DIG_W-1:0]      s_base;
    logic                  s_in_acc;
    logic                  s_out_acc;
    logic                  s_in_zero;
    logic                  s_quo_zero;

    logic                  s_div_start;
    logic [VALUE_BITS-1:0] s_div_dividend;
    t_div_stat             s_div_stat;
    logic [VALUE_BITS-1:0] s_div_quo;
    logic [DIG_W-1:0]      s_div_rem;

    logic                  s_buf_we;
    logic [ADDR_W-1:0]     s_buf_waddr;
    logic [DIG_W-1:0]      s_buf_wdata;
    logic                  s_buf_re;
    logic [DIG_W-1:0]      s_buf_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_upper <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_RADIX: r_radix <= i_cfg_data;
                CFG_UPPER: r_upper <= i_cfg_data[0];
                default:   r_radix <= r_radix;
            endcase
        end
    end

    // Clamp the base into the supported range
    always_comb begin
        if (r_radix < RADIX_MIN) begin
            s_base = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            s_base = RADIX_MAX;
        end else begin
            s_base = r_radix;
        end
    end

    assign s_in_acc   = i_value_valid && o_value_ready;
    assign s_out_acc  = o_digit_valid && i_digit_ready;
    assign s_in_zero  = (i_value == '0);
    assign s_quo_zero = (s_div_quo == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_in_acc) begin
                    n_state = s_in_zero ? ST_RD : ST_DIV;
                end
            end
            ST_DIV: begin
                if (s_div_stat.done && s_quo_zero) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (s_out_acc) begin
                    n_state = (r_ptr == '0) ? ST_IDLE : ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs and counters
    always_comb begin
        o_value_ready  = 1'b0;
        o_digit_valid  = 1'b0;
        s_div_start    = 1'b0;
        s_div_dividend = s_div_quo;
        s_buf_we       = 1'b0;
        s_buf_waddr    = r_count[ADDR_W-1:0];
        s_buf_wdata    = s_div_rem;
        s_buf_re       = 1'b0;
        n_count        = r_count;
        n_ptr          = r_ptr;
        unique case (r_state)
            ST_IDLE: begin
                o_value_ready  = 1'b1;
                s_div_dividend = i_value;
                if (s_in_acc) begin
                    if (s_in_zero) begin
                        // Zero gives the single digit zero, stored at the bottom
                        s_buf_we    = 1'b1;
                        s_buf_waddr = '0;
                        s_buf_wdata = '0;
                        n_count     = COUNT_W'(1);
                        n_ptr       = '0;
                    end else begin
                        s_div_start = 1'b1;
                        n_count     = '0;
                    end
                end
            end
            ST_DIV: begin
                if (s_div_stat.done) begin
                    s_buf_we    = 1'b1;
                    n_count     = r_count + COUNT_W'(1);
                    n_ptr       = r_count[ADDR_W-1:0];
                    s_div_start = !s_quo_zero;
                end
            end
            ST_RD: begin
                s_buf_re = 1'b1;
            end
            ST_OUT: begin
                o_digit_valid = 1'b1;
                if (s_out_acc && (r_ptr != '0)) begin
                    n_ptr = r_ptr - ADDR_W'(1);
                end
            end
            default: begin
                o_value_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    rdsc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_div_start),
        .i_dividend  (s_div_dividend),
        .i_base      (s_base),
        .o_stat      (s_div_stat),
        .o_quotient  (s_div_quo),
        .o_remainder (s_div_rem)
    );

    rdsc_buf u_buf (
        .i_clk   (i_clk),
        .i_we    (s_buf_we),
        .i_waddr (s_buf_waddr),
        .i_wdata (s_buf_wdata),
        .i_re    (s_buf_re),
        .i_raddr (r_ptr),
        .o_rdata (s_buf_rdata)
    );

    // Map the digit to its character
    always_comb begin
        o_digit_value = s_buf_rdata;
        if (s_buf_rdata < DIGIT_TEN) begin
            o_digit_char = CHAR_ZERO + CHAR_W'(s_buf_rdata);
        end else if (r_upper) begin
            o_digit_char = CHAR_UPPER_10 + CHAR_W'(s_buf_rdata);
        end else begin
            o_digit_char = CHAR_LOWER_10 + CHAR_W'(s_buf_rdata);
        end
        o_last_digit = (r_ptr == '0);
    end

    // A shown digit is always below the active base
    a_digit_in_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid |-> (o_digit_value < s_base))
        else $error("digit not below base");

    // The divider only finishes while the controller is dividing
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_stat.done |-> (r_state == ST_DIV))
        else $error("divider done outside division");

    // Digit count never exceeds the input width
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(VALUE_BITS))
        else $error("digit count overflow");

    // An accepted output with the last flag returns the unit to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digit_valid && i_digit_ready && o_last_digit) |=> o_value_ready)
        else $error("not idle after last digit");

endmodule

/* sv/rdsc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_div: bit-serial restoring divider
// Divides the dividend by a small base, one quotient bit per cycle, MSB first.
// Quotient and remainder are valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module rdsc_div
    import rdsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_dividend,
    input  logic [DIG_W-1:0]      i_base,
    output t_div_stat             o_stat,
    output logic [VALUE_BITS-1:0] o_quotient,
    output logic [DIG_W-1:0]      o_remainder
);

    logic [VALUE_BITS-1:0] r_quo;
    logic [DIG_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIG_W:0]        s_trial;
    logic                  s_qbit;
    logic [DIG_W:0]        s_rem_next;

    // Shift in the next dividend bit and try one subtract
    always_comb begin
        s_trial    = {r_rem, r_quo[VALUE_BITS-1]};
        s_qbit     = (s_trial >= {1'b0, i_base});
        s_rem_next = s_qbit ? (s_trial - {1'b0, i_base}) : s_trial;
    end

    // Control: load, count bits, flag completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: quotient shifts in, remainder stays below the base
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], s_qbit};
            r_rem <= s_rem_next[DIG_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* sv/rdsc_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsc_buf: digit buffer
// One write port and one registered read port over the stored digits.
// ----------------------------------------------------------------------------
module rdsc_buf
    import rdsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DIG_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DIG_W-1:0]  o_rdata
);

    logic [DIG_W-1:0] r_mem [BUF_DEPTH];
    logic [DIG_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
